FILE: rtl/core/min_jerk_trajectory_2d_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef MIN_JERK_TRAJECTORY_2D_TOP_MACROS_SVH
`define MIN_JERK_TRAJECTORY_2D_TOP_MACROS_SVH

// Plain property, sampled on clk, off while rst_n is low.
`define MJT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mjt check failed");

// Overlapping implication, sampled on clk, off while rst_n is low.
`define MJT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mjt check failed");

`endif

FILE: rtl/core/mjt_pkg.sv
package mjt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SFRAC         = 30;      // fraction bits of normalized time
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int DUR_W         = 31;
    localparam int S_W           = SFRAC + 1;

    localparam int S_DIV_LAT     = S_W;
    localparam int POLY_LAT      = 5;
    localparam int VEL_QW        = 32;
    localparam int AXIS_LAT      = 4 + VEL_QW;
    localparam int PIPE_LAT      = S_DIV_LAT + POLY_LAT + AXIS_LAT;
    localparam int LAT_TOTAL     = PIPE_LAT + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X  = 3'd0,
        REG_START_Y  = 3'd1,
        REG_END_X    = 3'd2,
        REG_END_Y    = 3'd3,
        REG_DURATION = 3'd4
    } mjt_reg_t;

    typedef enum logic [1:0] {
        CASE_RUN,
        CASE_PRE,
        CASE_POST
    } mjt_case_t;

    // One axis at the end of its pipe: position and the velocity divider result.
    typedef struct packed {
        logic signed [31:0] pos;
        logic               q_neg;
        logic               ovf;
        logic [VEL_QW-1:0]  quo;
    } mjt_axis_res_t;

endpackage

FILE: rtl/core/mjt_pipe_div.sv
module mjt_pipe_div #(
    parameter int QW = mjt_pkg::S_W
) (
    input  logic                       clk,
    input  logic [mjt_pkg::DUR_W-1:0]  rem_in,
    input  logic [QW-1:0]              lo_in,
    input  logic [mjt_pkg::DUR_W-1:0]  dvs,
    output logic [QW-1:0]              quo
);
    import mjt_pkg::*;

    // Restoring division, one quotient bit per stage. rem_in must be below dvs.
    logic [DUR_W-1:0] rem_reg [QW-1];
    logic [QW-1:0]    lo_reg  [QW-1];
    logic [QW-1:0]    q_reg   [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_step
            logic [DUR_W-1:0] rem_cur;
            logic [QW-1:0]    lo_cur;
            logic [QW-1:0]    q_cur;
            logic [DUR_W:0]   trial;
            logic [DUR_W:0]   diff;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign rem_cur = rem_in;
                assign lo_cur  = lo_in;
                assign q_cur   = '0;
            end
            else
            begin : g_next
                assign rem_cur = rem_reg[k-1];
                assign lo_cur  = lo_reg[k-1];
                assign q_cur   = q_reg[k-1];
            end

            assign trial = {rem_cur, lo_cur[QW-1]};
            assign diff  = trial - {1'b0, dvs};
            assign ge    = (trial >= {1'b0, dvs});

            always_ff @(posedge clk)
            begin
                q_reg[k] <= {q_cur[QW-2:0], ge};
            end

            if (k < QW - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    rem_reg[k] <= ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
                    lo_reg[k]  <= lo_cur << 1;
                end
            end
        end
    endgenerate

    assign quo = q_reg[QW-1];

endmodule

FILE: rtl/core/mjt_poly.sv
module mjt_poly (
    input  logic                    clk,
    input  logic [mjt_pkg::S_W-1:0] s,
    output logic [mjt_pkg::S_W-1:0] b,
    output logic [mjt_pkg::S_W-1:0] v
);
    import mjt_pkg::*;

    localparam logic signed [37:0] ONE_S = 38'sd1 <<< SFRAC;
    localparam logic signed [37:0] V_MAX = 38'sd15 <<< (SFRAC - 3);

    logic [2*S_W-1:0] p2_reg, p3_reg, p4_reg, p5_reg;
    logic [S_W-1:0]   s_1_reg, s_2_reg, s_3_reg;
    logic [S_W-1:0]   s2_2_reg, s2_3_reg, s2_4_reg;
    logic [S_W-1:0]   s3_3_reg, s3_4_reg;
    logic [S_W-1:0]   s4_4_reg;
    logic [S_W-1:0]   b_reg, v_reg;

    logic [S_W-1:0]   s2_w, s3_w, s4_w, s5_w;
    logic signed [37:0] e2, e3, e4, e5, b_w, v_w;
    logic [S_W-1:0]   b_next, v_next;

    // each power is floor(prev * s / 2^30), so the chain stays serial
    assign s2_w = p2_reg[SFRAC +: S_W];
    assign s3_w = p3_reg[SFRAC +: S_W];
    assign s4_w = p4_reg[SFRAC +: S_W];
    assign s5_w = p5_reg[SFRAC +: S_W];

    always_comb
    begin
        e2  = 38'(s2_4_reg);
        e3  = 38'(s3_4_reg);
        e4  = 38'(s4_4_reg);
        e5  = 38'(s5_w);
        b_w = 38'sd10 * e3 - 38'sd15 * e4 + 38'sd6 * e5;
        v_w = 38'sd30 * e2 - 38'sd60 * e3 + 38'sd30 * e4;
        if (b_w < 38'sd0)
            b_next = '0;
        else if (b_w > ONE_S)
            b_next = ONE_S[S_W-1:0];
        else
            b_next = b_w[S_W-1:0];
        if (v_w < 38'sd0)
            v_next = '0;
        else if (v_w > V_MAX)
            v_next = V_MAX[S_W-1:0];
        else
            v_next = v_w[S_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        p2_reg   <= s * s;
        s_1_reg  <= s;

        p3_reg   <= s2_w * s_1_reg;
        s_2_reg  <= s_1_reg;
        s2_2_reg <= s2_w;

        p4_reg   <= s3_w * s_2_reg;
        s_3_reg  <= s_2_reg;
        s2_3_reg <= s2_2_reg;
        s3_3_reg <= s3_w;

        p5_reg   <= s4_w * s_3_reg;
        s2_4_reg <= s2_3_reg;
        s3_4_reg <= s3_3_reg;
        s4_4_reg <= s4_w;

        b_reg    <= b_next;
        v_reg    <= v_next;
    end

    assign b = b_reg;
    assign v = v_reg;

endmodule

FILE: rtl/core/mjt_axis.sv
module mjt_axis #(
    parameter int FRAC_BITS = mjt_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic signed [31:0]         st,
    input  logic signed [31:0]         en,
    input  logic [mjt_pkg::DUR_W-1:0]  dur,
    input  logic [mjt_pkg::S_W-1:0]    b,
    input  logic [mjt_pkg::S_W-1:0]    v,
    output mjt_pkg::mjt_axis_res_t     res
);
    import mjt_pkg::*;

    localparam int NW = 34 + FRAC_BITS;     // |q| << FRAC_BITS plus half the duration
    localparam logic signed [63:0] HALF = 64'sd1 <<< (SFRAC - 1);

    typedef struct packed {
        logic signed [31:0] pos;
        logic               q_neg;
        logic               ovf;
    } side_t;

    logic signed [32:0] d;
    logic signed [49:0] pb_lo_reg, pv_lo_reg;
    logic signed [48:0] pb_hi_reg, pv_hi_reg;
    logic signed [63:0] pb_reg, pv_reg;
    logic signed [63:0] pb_w, pv_w;
    logic signed [33:0] rb_reg, rq_reg;
    logic signed [34:0] pos_w;
    logic signed [31:0] pos_sat;
    logic [32:0]        q_mag;
    logic [NW-1:0]      num;
    logic [NW-33:0]     n_hi;
    logic               ovf_w;
    side_t              side_next;
    side_t              side_reg [VEL_QW+1];
    logic [DUR_W-1:0]   rem_init_reg;
    logic [VEL_QW-1:0]  lo_init_reg;
    logic [VEL_QW-1:0]  quo_w;

    function automatic logic signed [33:0] rnd30(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x + (x[63] ? (HALF - 64'sd1) : HALF);
        return 34'(y >>> SFRAC);
    endfunction

    assign d    = 33'(en) - 33'(st);
    assign pb_w = 64'(pb_lo_reg) + (64'(pb_hi_reg) <<< 16);
    assign pv_w = 64'(pv_lo_reg) + (64'(pv_hi_reg) <<< 16);

    always_comb
    begin
        pos_w = 35'(st) + 35'(rb_reg);
        if (pos_w > 35'sd2147483647)
            pos_sat = 32'sh7FFFFFFF;
        else if (pos_w < -35'sd2147483648)
            pos_sat = 32'sh80000000;
        else
            pos_sat = pos_w[31:0];
        q_mag = rq_reg[33] ? 33'(-rq_reg) : 33'(rq_reg);
        num   = (NW'(q_mag) << FRAC_BITS) + NW'(dur >> 1);
        n_hi  = num[NW-1:VEL_QW];
        ovf_w = (32'(n_hi) >= 32'(dur));
        side_next.pos   = pos_sat;
        side_next.q_neg = rq_reg[33];
        side_next.ovf   = ovf_w;
    end

    always_ff @(posedge clk)
    begin
        // 33 x 31 products split in halves of b and v
        pb_lo_reg    <= d * $signed({1'b0, b[15:0]});
        pb_hi_reg    <= d * $signed({1'b0, b[S_W-1:16]});
        pv_lo_reg    <= d * $signed({1'b0, v[15:0]});
        pv_hi_reg    <= d * $signed({1'b0, v[S_W-1:16]});
        pb_reg       <= pb_w;
        pv_reg       <= pv_w;
        rb_reg       <= rnd30(pb_reg);
        rq_reg       <= rnd30(pv_reg);
        side_reg[0]  <= side_next;
        rem_init_reg <= DUR_W'(n_hi);
        lo_init_reg  <= num[VEL_QW-1:0];
        for (int i = 1; i <= VEL_QW; i++)
            side_reg[i] <= side_reg[i-1];
    end

    // rounded velocity scaled by 1/duration; high quotient bits become the ovf flag
    mjt_pipe_div #(
        .QW     (VEL_QW)
    ) u_div (
        .clk    (clk),
        .rem_in (rem_init_reg),
        .lo_in  (lo_init_reg),
        .dvs    (dur),
        .quo    (quo_w)
    );

    assign res.pos   = side_reg[VEL_QW].pos;
    assign res.q_neg = side_reg[VEL_QW].q_neg;
    assign res.ovf   = side_reg[VEL_QW].ovf;
    assign res.quo   = quo_w;

endmodule

FILE: rtl/core/min_jerk_trajectory_2d_top.sv
// Channel   Signals                                   Transfer when
// ------    ----------------------------------------  ------------------------
// input     start, busy, time_now                     start && !busy
// result    done, pos_x, pos_y, vel_x, vel_y          done (one cycle)
// config    cfg_we, cfg_index, cfg_data               cfg_we
//
// One time value enters every cycle; busy is always low.
// The result passes through the 31-step normalized-time divider, the
// 5-stage power chain and the 32-step velocity divider in each axis.
// rst_n clears the valid pipe and loads the register reset values.
// The result side has no back-pressure; done is a single-cycle strobe.
module min_jerk_trajectory_2d_top #(
    parameter int FRAC_BITS = mjt_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [31:0]              time_now,
    input  logic                            cfg_we,
    input  logic [mjt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mjt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            done,
    output logic signed [31:0]              pos_x,
    output logic signed [31:0]              pos_y,
    output logic signed [31:0]              vel_x,
    output logic signed [31:0]              vel_y
);
    import mjt_pkg::*;

    localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1) << FRAC_BITS;

    logic signed [31:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [DUR_W-1:0]   duration_reg;

    logic               accept;
    logic               in_vld_reg;
    mjt_case_t          in_case_reg, in_case_next;
    logic [31:0]        t_reg;

    logic [S_W-1:0]     s_w, b_w, v_w;
    mjt_axis_res_t      res_x, res_y;

    logic               vld_pipe_reg  [PIPE_LAT];
    mjt_case_t          case_pipe_reg [PIPE_LAT];

    logic               done_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic signed [31:0] pos_x_next, pos_y_next, vel_x_next, vel_y_next;

    function automatic logic signed [31:0] vel_of(input mjt_axis_res_t r);
        if (r.ovf)
            return r.q_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        if (r.q_neg)
            return (r.quo > 32'h80000000) ? 32'sh80000000 : $signed(-r.quo);
        return r.quo[31] ? 32'sh7FFFFFFF : $signed(r.quo);
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            end_x_reg    <= '0;
            end_y_reg    <= '0;
            duration_reg <= DUR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X:  start_x_reg  <= cfg_data;
                REG_START_Y:  start_y_reg  <= cfg_data;
                REG_END_X:    end_x_reg    <= cfg_data;
                REG_END_Y:    end_y_reg    <= cfg_data;
                REG_DURATION: duration_reg <= cfg_data[DUR_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        if (time_now[31])
            in_case_next = CASE_PRE;
        else if (duration_reg == '0 || time_now > $signed({1'b0, duration_reg}))
            in_case_next = CASE_POST;
        else
            in_case_next = CASE_RUN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            in_case_reg <= CASE_RUN;
            done_reg    <= 1'b0;
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                vld_pipe_reg[i]  <= 1'b0;
                case_pipe_reg[i] <= CASE_RUN;
            end
        end
        else
        begin
            in_vld_reg       <= accept;
            in_case_reg      <= in_case_next;
            vld_pipe_reg[0]  <= in_vld_reg;
            case_pipe_reg[0] <= in_case_reg;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                vld_pipe_reg[i]  <= vld_pipe_reg[i-1];
                case_pipe_reg[i] <= case_pipe_reg[i-1];
            end
            done_reg <= vld_pipe_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= time_now;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        vel_x_reg <= vel_x_next;
        vel_y_reg <= vel_y_next;
    end

    // s = t * 2^30 / duration; t <= duration so t>>1 is a valid first remainder
    mjt_pipe_div #(
        .QW     (S_DIV_LAT)
    ) u_sdiv (
        .clk    (clk),
        .rem_in ({1'b0, t_reg[30:1]}),
        .lo_in  ({t_reg[0], {(S_DIV_LAT-1){1'b0}}}),
        .dvs    (duration_reg),
        .quo    (s_w)
    );

    mjt_poly u_poly (
        .clk (clk),
        .s   (s_w),
        .b   (b_w),
        .v   (v_w)
    );

    mjt_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .clk (clk),
        .st  (start_x_reg),
        .en  (end_x_reg),
        .dur (duration_reg),
        .b   (b_w),
        .v   (v_w),
        .res (res_x)
    );

    mjt_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .clk (clk),
        .st  (start_y_reg),
        .en  (end_y_reg),
        .dur (duration_reg),
        .b   (b_w),
        .v   (v_w),
        .res (res_y)
    );

    always_comb
    begin
        case (case_pipe_reg[PIPE_LAT-1])
            CASE_PRE:
            begin
                pos_x_next = start_x_reg;
                pos_y_next = start_y_reg;
                vel_x_next = '0;
                vel_y_next = '0;
            end
            CASE_POST:
            begin
                pos_x_next = end_x_reg;
                pos_y_next = end_y_reg;
                vel_x_next = '0;
                vel_y_next = '0;
            end
            default:
            begin
                pos_x_next = res_x.pos;
                pos_y_next = res_y.pos;
                vel_x_next = vel_of(res_x);
                vel_y_next = vel_of(res_y);
            end
        endcase
    end

    assign done  = done_reg;
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign vel_x = vel_x_reg;
    assign vel_y = vel_y_reg;

endmodule

FILE: rtl/core/mjt_checker.sv
`include "min_jerk_trajectory_2d_top_macros.svh"

module mjt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic signed [31:0]              time_now,
    input logic                            done,
    input logic signed [31:0]              vel_x,
    input logic signed [31:0]              vel_y
);
    import mjt_pkg::*;

    logic pre_xfer;
    logic at_rest;

    assign pre_xfer = start && !busy && time_now[31];
    assign at_rest  = (vel_x == 32'sd0) && (vel_y == 32'sd0);

    `MJT_ASSERT(a_never_busy, !busy)

    `MJT_ASSERT_IMP(a_transfer_gives_done, start && !busy, ##LAT_TOTAL done)

    `MJT_ASSERT_IMP(a_done_has_transfer, done, $past(start && !busy, LAT_TOTAL))

    // a negative time must come back with the axes at rest
    `MJT_ASSERT_IMP(a_pre_start_at_rest, done && $past(pre_xfer, LAT_TOTAL), at_rest)

endmodule

bind min_jerk_trajectory_2d_top mjt_checker u_mjt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .time_now (time_now),
    .done     (done),
    .vel_x    (vel_x),
    .vel_y    (vel_y)
);
